@@ rtl/core/pmclk_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmclk_pkg
// Shared types and constants for the paged memory clock replacement unit.
// ----------------------------------------------------------------------------
package pmclk_pkg;

  localparam int NUM_FRAMES     = 256;
  localparam int NUM_PROCS      = 18;
  localparam int PAGES_PER_PROC = 32;
  localparam int TOTAL_PAGES    = NUM_PROCS * PAGES_PER_PROC;
  localparam int FRAME_W        = $clog2(NUM_FRAMES);
  localparam int PAGE_W         = $clog2(TOTAL_PAGES);
  localparam int IDX_W          = $clog2(PAGES_PER_PROC);
  localparam int PID_W          = 5;

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TERM  = 2'd2;
  localparam logic [1:0] REQ_SPARE = 2'd3;

  localparam logic [1:0] ST_HIT     = 2'd0;
  localparam logic [1:0] ST_FREE    = 2'd1;
  localparam logic [1:0] ST_REPLACE = 2'd2;
  localparam logic [1:0] ST_TERM    = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [4:0]  process_id;
    logic [14:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] frame;
  } rsp_t;

  // page table entry: valid bit and the frame it maps to
  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] frame;
  } map_ent_t;

  // per frame flags
  typedef struct packed {
    logic valid;
    logic referenced;
    logic dirty;
  } fflags_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_OWN,
    S_CHECK,
    S_SCAN,
    S_SCHK,
    S_SWEEP,
    S_SWCHK,
    S_LOAD,
    S_TLOOK,
    S_TOWN,
    S_TCHECK,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

@@ rtl/core/paged_memory_clock_replacement_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// paged_memory_clock_replacement_unit
// Page table with second chance (clock) frame replacement.
// ----------------------------------------------------------------------------
// One request is handled at a time; req_ready and cfg_ready are high only
// while the unit is idle. After reset a clearing pass marks every page
// table entry invalid and clears the first 256 frame flag words; nothing is
// accepted meanwhile. A hit reads the page table, then the owner and the
// frame flags, then compares. A fault into a free frame then examines the
// frame flags from frame 0, one frame after another, and loads the chosen
// frame. With no free frame the clock sweep follows, visiting up to 257
// frames, and then loads the victim. A terminate walks the process's 32
// page table entries, reading each entry, then its owner and flags, then
// checking it. The page table (576 entries, valid bit in the entry), the
// frame owner store and the frame flags are memories with one registered
// read each. The result is held in registers and offered until taken; the
// next request is accepted in the cycle after that transfer.
// ----------------------------------------------------------------------------
module paged_memory_clock_replacement_unit (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire                   cfg_data,
  input  wire                   req_valid,
  output logic                  req_ready,
  input  pmclk_pkg::req_t       req,
  output logic                  rsp_valid,
  input  wire                   rsp_ready,
  output pmclk_pkg::rsp_t       rsp
);

  localparam int FW = pmclk_pkg::FRAME_W;
  localparam int PW = pmclk_pkg::PAGE_W;
  localparam int IW = pmclk_pkg::IDX_W;

  pmclk_pkg::state_t state, state_next;

  logic page_size_mode;

  // memories
  pmclk_pkg::map_ent_t pmap  [pmclk_pkg::TOTAL_PAGES];
  logic [PW-1:0]       owner [pmclk_pkg::NUM_FRAMES];
  pmclk_pkg::fflags_t  flags [pmclk_pkg::NUM_FRAMES];
  pmclk_pkg::map_ent_t map_rd;
  logic [PW-1:0]       own_rd;
  pmclk_pkg::fflags_t  fl_rd;

  logic [FW-1:0] hand;
  logic [FW-1:0] ptr;       // scan pointer / chosen frame
  logic [IW-1:0] tidx;      // terminate walk index
  logic [PW-1:0] page;
  logic [PW-1:0] base;
  logic [PW-1:0] clr_idx;   // clearing pass pointer
  logic          is_write;
  logic [1:0]    status_r;

  // memory write controls
  logic                map_we;
  logic [PW-1:0]       map_waddr;
  pmclk_pkg::map_ent_t map_wdata;
  logic                fl_we;
  logic [FW-1:0]       fl_waddr;
  pmclk_pkg::fflags_t  fl_wdata;

  // request decode
  logic [4:0]    pid_mod;
  logic [IW-1:0] idx_in;
  always_comb begin
    pid_mod = (req.process_id >= 5'(pmclk_pkg::NUM_PROCS)) ?
              5'(req.process_id - 5'(pmclk_pkg::NUM_PROCS)) : req.process_id;
    idx_in  = page_size_mode ? {1'b0, req.address[14:11]} : req.address[14:10];
  end

  wire [PW-1:0] cur_page = base + PW'(tidx);
  wire          accept   = req_valid && req_ready;

  // page hit: entry valid, frame valid and still owned by this page
  wire look_hit = map_rd.valid && fl_rd.valid && (own_rd == page);
  wire term_own = map_rd.valid && fl_rd.valid && (own_rd == cur_page);

  // read addresses; every read is registered
  logic [PW-1:0] map_addr;
  logic [FW-1:0] fl_addr;
  always_comb begin
    map_addr = page;
    fl_addr  = map_rd.frame;
    case (state)
      pmclk_pkg::S_TLOOK, pmclk_pkg::S_TOWN: map_addr = cur_page;
      pmclk_pkg::S_SCAN:  fl_addr = ptr;
      pmclk_pkg::S_SWEEP: fl_addr = hand;
      default: ;
    endcase
  end
  always_ff @(posedge clk) begin
    map_rd <= pmap[map_addr];
    own_rd <= owner[map_rd.frame];
    fl_rd  <= flags[fl_addr];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pmclk_pkg::S_CLEAR:
        if (clr_idx == PW'(pmclk_pkg::TOTAL_PAGES - 1)) state_next = pmclk_pkg::S_IDLE;
      pmclk_pkg::S_IDLE:
        if (accept) begin
          state_next = (req.req_type == pmclk_pkg::REQ_TERM) ?
                       pmclk_pkg::S_TLOOK : pmclk_pkg::S_LOOK;
        end
      pmclk_pkg::S_LOOK:  state_next = pmclk_pkg::S_OWN;
      pmclk_pkg::S_OWN:   state_next = pmclk_pkg::S_CHECK;
      pmclk_pkg::S_CHECK: begin
        // map_rd, own_rd and fl_rd all settled for this page
        state_next = look_hit ? pmclk_pkg::S_DONE : pmclk_pkg::S_SCAN;
      end
      pmclk_pkg::S_SCAN:  state_next = pmclk_pkg::S_SCHK;
      pmclk_pkg::S_SCHK: begin
        if (!fl_rd.valid) begin
          state_next = pmclk_pkg::S_LOAD;
        end else if (ptr == FW'(pmclk_pkg::NUM_FRAMES - 1)) begin
          state_next = pmclk_pkg::S_SWEEP;
        end else begin
          state_next = pmclk_pkg::S_SCAN;
        end
      end
      pmclk_pkg::S_SWEEP: state_next = pmclk_pkg::S_SWCHK;
      pmclk_pkg::S_SWCHK: begin
        state_next = fl_rd.referenced ? pmclk_pkg::S_SWEEP : pmclk_pkg::S_LOAD;
      end
      pmclk_pkg::S_LOAD:  state_next = pmclk_pkg::S_DONE;
      pmclk_pkg::S_TLOOK: state_next = pmclk_pkg::S_TOWN;
      pmclk_pkg::S_TOWN:  state_next = pmclk_pkg::S_TCHECK;
      pmclk_pkg::S_TCHECK: begin
        state_next = (tidx == IW'(pmclk_pkg::PAGES_PER_PROC - 1)) ?
                     pmclk_pkg::S_DONE : pmclk_pkg::S_TLOOK;
      end
      pmclk_pkg::S_DONE: if (rsp_ready) state_next = pmclk_pkg::S_IDLE;
      default: state_next = pmclk_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_ready  = (state == pmclk_pkg::S_IDLE);
    cfg_ready  = (state == pmclk_pkg::S_IDLE);
    rsp_valid  = (state == pmclk_pkg::S_DONE);
    rsp.status = status_r;
    rsp.frame  = 8'(ptr);
  end

  // memory write controls
  always_comb begin
    map_we    = 1'b0;
    map_waddr = page;
    map_wdata = '0;
    fl_we     = 1'b0;
    fl_waddr  = ptr;
    fl_wdata  = '0;
    case (state)
      pmclk_pkg::S_CLEAR: begin
        // invalidate the page table; clear the frame flags on the way
        map_we    = 1'b1;
        map_waddr = clr_idx;
        fl_we     = (clr_idx < PW'(pmclk_pkg::NUM_FRAMES));
        fl_waddr  = clr_idx[FW-1:0];
      end
      pmclk_pkg::S_CHECK: begin
        if (look_hit) begin
          // hit: mark referenced, dirty on write
          fl_we               = 1'b1;
          fl_waddr            = map_rd.frame;
          fl_wdata.valid      = 1'b1;
          fl_wdata.referenced = 1'b1;
          fl_wdata.dirty      = fl_rd.dirty | is_write;
        end
      end
      pmclk_pkg::S_SWCHK: begin
        if (fl_rd.referenced) begin
          // second chance: drop the reference bit
          fl_we               = 1'b1;
          fl_waddr            = hand;
          fl_wdata            = fl_rd;
          fl_wdata.referenced = 1'b0;
        end
      end
      pmclk_pkg::S_LOAD: begin
        map_we              = 1'b1;
        map_waddr           = page;
        map_wdata.valid     = 1'b1;
        map_wdata.frame     = ptr;
        fl_we               = 1'b1;
        fl_waddr            = ptr;
        fl_wdata.valid      = 1'b1;
        fl_wdata.referenced = 1'b1;
      end
      pmclk_pkg::S_TCHECK: begin
        // drop the entry; free the frame only if this page still owns it
        map_we    = 1'b1;
        map_waddr = cur_page;
        fl_we     = term_own;
        fl_waddr  = map_rd.frame;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= pmclk_pkg::S_CLEAR;
      page_size_mode <= 1'b0;
      hand           <= '0;
      clr_idx        <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) page_size_mode <= cfg_data;
      case (state)
        pmclk_pkg::S_CLEAR: clr_idx <= clr_idx + 1'b1;
        pmclk_pkg::S_IDLE: begin
          if (accept) begin
            base     <= PW'(pid_mod) * PW'(pmclk_pkg::PAGES_PER_PROC);
            page     <= PW'(pid_mod) * PW'(pmclk_pkg::PAGES_PER_PROC) + PW'(idx_in);
            is_write <= (req.req_type == pmclk_pkg::REQ_WRITE);
            tidx     <= '0;
            ptr      <= '0;
          end
        end
        pmclk_pkg::S_CHECK: begin
          if (look_hit) begin
            ptr      <= map_rd.frame;
            status_r <= pmclk_pkg::ST_HIT;
          end
        end
        pmclk_pkg::S_SCHK: begin
          if (!fl_rd.valid) begin
            status_r <= pmclk_pkg::ST_FREE;
          end else if (ptr != FW'(pmclk_pkg::NUM_FRAMES - 1)) begin
            ptr <= ptr + 1'b1;
          end
        end
        pmclk_pkg::S_SWCHK: begin
          // advance hand past the frame just examined
          hand <= (hand == FW'(pmclk_pkg::NUM_FRAMES - 1)) ? '0 : hand + 1'b1;
          if (!fl_rd.referenced) begin
            ptr      <= hand;
            status_r <= pmclk_pkg::ST_REPLACE;
          end
        end
        pmclk_pkg::S_TCHECK: begin
          if (tidx == IW'(pmclk_pkg::PAGES_PER_PROC - 1)) begin
            ptr      <= '0;
            status_r <= pmclk_pkg::ST_TERM;
          end else begin
            tidx <= tidx + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (map_we) pmap[map_waddr] <= map_wdata;
    if (fl_we) flags[fl_waddr] <= fl_wdata;
    if (state == pmclk_pkg::S_LOAD) owner[ptr] <= page;
  end

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the paged memory clock replacement unit.
// ----------------------------------------------------------------------------
// Requests go in over a valid/ready channel and responses come back over
// another. A frame table model in the bench predicts each response (hit,
// free-frame fault, clock replacement, terminate) and a small scoreboard
// compares every response in order. Both page size modes are exercised.
// ----------------------------------------------------------------------------
module tb;

  localparam int NFR = pmclk_pkg::NUM_FRAMES;
  localparam int NPG = pmclk_pkg::TOTAL_PAGES;

  // Frame table model plus the queue of responses still owed by the unit.
  class frame_table_sb;
    bit              fr_valid [NFR];
    bit              fr_ref   [NFR];
    bit              fr_dirty [NFR];
    int unsigned     fr_owner [NFR];
    bit              pg_valid [NPG];
    int unsigned     pg_frame [NPG];
    int unsigned     hand;
    bit              wide_pages;
    pmclk_pkg::rsp_t pending[$];
    int              errors;
    int              n_hit, n_free, n_repl, n_term;

    function void clear();
      foreach (fr_valid[i]) begin
        fr_valid[i] = 0; fr_ref[i] = 0; fr_dirty[i] = 0; fr_owner[i] = 0;
      end
      foreach (pg_valid[i]) begin
        pg_valid[i] = 0; pg_frame[i] = 0;
      end
      hand = 0;
      wide_pages = 0;
    endfunction

    function int unsigned next_victim();
      int unsigned h;
      forever begin
        h = hand;
        hand = (h == NFR - 1) ? 0 : h + 1;
        if (!fr_ref[h]) return h;
        fr_ref[h] = 0;
      end
    endfunction

    // Note an accepted request and queue the response it should produce.
    function void note_request(pmclk_pkg::req_t r);
      int unsigned pid, base, idx, pg, f;
      bit hit, found;
      pmclk_pkg::rsp_t e;
      pid  = r.process_id % pmclk_pkg::NUM_PROCS;
      base = pid * pmclk_pkg::PAGES_PER_PROC;
      f    = 0;
      if (r.req_type == pmclk_pkg::REQ_TERM) begin
        for (int i = 0; i < pmclk_pkg::PAGES_PER_PROC; i++) begin
          pg = base + i;
          if (pg_valid[pg]) begin
            if (fr_valid[pg_frame[pg]] && fr_owner[pg_frame[pg]] == pg) begin
              fr_valid[pg_frame[pg]] = 0;
              fr_ref[pg_frame[pg]]   = 0;
              fr_dirty[pg_frame[pg]] = 0;
            end
            pg_valid[pg] = 0;
          end
        end
        e.status = pmclk_pkg::ST_TERM;
        n_term++;
      end else begin
        idx = r.address / 1024;
        if (wide_pages) idx = idx >> 1;
        idx = idx % pmclk_pkg::PAGES_PER_PROC;
        pg  = base + idx;
        hit = pg_valid[pg] && fr_valid[pg_frame[pg]] && fr_owner[pg_frame[pg]] == pg;
        if (hit) begin
          f = pg_frame[pg];
          fr_ref[f] = 1;
          if (r.req_type == pmclk_pkg::REQ_WRITE) fr_dirty[f] = 1;
          e.status = pmclk_pkg::ST_HIT;
          n_hit++;
        end else begin
          found = 0;
          for (int i = 0; i < NFR && !found; i++)
            if (!fr_valid[i]) begin
              f = i; found = 1;
            end
          if (found) begin
            e.status = pmclk_pkg::ST_FREE;
            n_free++;
          end else begin
            f = next_victim();
            e.status = pmclk_pkg::ST_REPLACE;
            n_repl++;
          end
          fr_valid[f] = 1; fr_ref[f] = 1; fr_dirty[f] = 0; fr_owner[f] = pg;
          pg_valid[pg] = 1; pg_frame[pg] = f;
        end
      end
      e.frame = f[7:0];
      pending.push_back(e);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    // Check one response against the oldest pending one.
    task check_response(pmclk_pkg::rsp_t got);
      pmclk_pkg::rsp_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected response status=%0d frame=%0d",
                         got.status, got.frame));
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status)
        report($sformatf("status got %0d exp %0d", got.status, e.status));
      if (got.frame !== e.frame)
        report($sformatf("frame got %0d exp %0d", got.frame, e.frame));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic cfg_data = 0;
  logic req_valid = 0;
  logic req_ready;
  pmclk_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 0;
  pmclk_pkg::rsp_t rsp;

  frame_table_sb sb;
  bit     rsp_idle_off;
  int     quiet_cycles = 0;
  longint accepted;

  always #1 clk = ~clk;

  paged_memory_clock_replacement_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  // Response side: stall in random bursts, check on every transfer.
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (rst) continue;
      if (rsp_valid && rsp_ready) sb.check_response(rsp);
      if (!rsp_idle_off && $urandom_range(0, 5) == 0) begin
        rsp_ready <= 0;
        gap = $urandom_range(1, 8);
        repeat (gap) begin
          @(posedge clk);
          if (rsp_valid && rsp_ready) sb.check_response(rsp);
        end
      end
      rsp_ready <= 1;
    end
  end

  // Watchdog: count cycles with no transfer on any channel.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Drive one request; hold valid and payload until the transfer. Valid
  // stays up after the transfer only when the next request follows at once.
  task automatic send_req(pmclk_pkg::req_t r, bit allow_gap);
    int gap;
    if (allow_gap && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      req_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    sb.note_request(r);
    accepted++;
  endtask

  task automatic drain();
    req_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  // Write the page size mode; only called with the unit idle.
  task automatic set_mode(bit m);
    cfg_valid <= 1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    sb.wide_pages = m;
    cfg_valid <= 0;
  endtask

  function automatic pmclk_pkg::req_t make_req(logic [1:0] t, logic [4:0] p,
                                               logic [14:0] a);
    pmclk_pkg::req_t r;
    r.req_type = t; r.process_id = p; r.address = a;
    return r;
  endfunction

  // Random request: mostly accesses over a working set that overflows the
  // frames, with occasional terminates and odd encodings.
  function automatic pmclk_pkg::req_t rand_req();
    int unsigned k;
    logic [1:0] t;
    k = $urandom_range(0, 99);
    if (k < 6) t = pmclk_pkg::REQ_TERM;
    else if (k < 8) t = pmclk_pkg::REQ_SPARE;
    else t = (k < 50) ? pmclk_pkg::REQ_READ : pmclk_pkg::REQ_WRITE;
    return make_req(t, ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                   : 5'($urandom_range(0, 17)),
                    15'($urandom_range(0, 32767)));
  endfunction

  initial begin
    sb = new();
    sb.clear();
    rsp_idle_off = 0;
    accepted = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: field extremes, every request type, write hit then read hit,
    // out of range process, unused type, terminate.
    send_req(make_req(pmclk_pkg::REQ_READ, 5'd0, 15'd0), 0);
    send_req(make_req(pmclk_pkg::REQ_WRITE, 5'd0, 15'd100), 0);
    send_req(make_req(pmclk_pkg::REQ_READ, 5'd0, 15'd0), 0);
    send_req(make_req(pmclk_pkg::REQ_WRITE, 5'd17, 15'h7FFF), 0);
    send_req(make_req(pmclk_pkg::REQ_SPARE, 5'd17, 15'h7FFF), 0);
    send_req(make_req(pmclk_pkg::REQ_READ, 5'd31, 15'h7C00), 0);
    send_req(make_req(pmclk_pkg::REQ_READ, 5'd18, 15'd1024), 0);
    send_req(make_req(pmclk_pkg::REQ_TERM, 5'd0, 15'h7FFF), 0);
    send_req(make_req(pmclk_pkg::REQ_READ, 5'd0, 15'd0), 0);
    send_req(make_req(pmclk_pkg::REQ_TERM, 5'd31, 15'd0), 0);
    send_req(make_req(pmclk_pkg::REQ_TERM, 5'd5, 15'd0), 0);
    drain();
    set_mode(1);
    send_req(make_req(pmclk_pkg::REQ_READ, 5'd3, 15'd2047), 0);
    send_req(make_req(pmclk_pkg::REQ_READ, 5'd3, 15'd1024), 0);
    send_req(make_req(pmclk_pkg::REQ_WRITE, 5'd3, 15'h7FFF), 0);
    drain();
    set_mode(0);

    // Fill all frames so that the clock sweep runs, then random traffic.
    for (int i = 0; i < 300; i++)
      send_req(make_req(pmclk_pkg::REQ_READ, 5'(i / 32), 15'((i % 32) * 1024)), 1);
    for (int i = 0; i < 300; i++) send_req(rand_req(), 1);
    // Hold off until the unit has nothing outstanding.
    drain();
    set_mode(1);
    for (int i = 0; i < 250; i++) send_req(rand_req(), 1);
    drain();
    set_mode(0);
    rsp_idle_off = 1;
    for (int i = 0; i < 250; i++) send_req(rand_req(), 0);
    drain();

    $display("Covered %0d requests: %0d hits, %0d free faults, %0d replacements,",
             accepted, sb.n_hit, sb.n_free, sb.n_repl);
    $display("%0d terminates; both page size modes used, with stalls on both channels.",
             sb.n_term);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

@@ paged_memory_clock_replacement_unit.f @@
rtl/core/pmclk_pkg.sv
rtl/core/paged_memory_clock_replacement_unit.sv
tb/sv/tb.sv
